[rtl/tod_pkg.sv]
// Tilt orientation debouncer: shared types, codes and reset constants.
// Used by every module of the block; no dependencies of its own.
package tod_pkg;

  localparam int ACCEL_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int AGREE_W = 4;
  localparam int FLAT_W  = 31;
  localparam int ROT_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [AGREE_W-1:0] RUN_MAX = 4'd15;

  // Register reset values (flat threshold is 0.35 g squared in Q6.24)
  localparam logic               AUTO_EN_RST = 1'b1;
  localparam logic [AGREE_W-1:0] AGREE_RST   = 4'd3;
  localparam logic [FLAT_W-1:0]  FLAT_SQ_RST = 31'd2055208;

  // Display rotation in quarter turns
  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO_ENABLE = 2'd0,
    CFG_AGREE_THR   = 2'd1,
    CFG_FLAT_SQ     = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    POSE_NONE           = 3'd0,
    POSE_FLAT           = 3'd1,
    POSE_LANDSCAPE      = 3'd2,
    POSE_LANDSCAPE_FLIP = 3'd3,
    POSE_PORTRAIT_RIGHT = 3'd4,
    POSE_PORTRAIT_LEFT  = 3'd5
  } pose_e;

  typedef struct packed {
    logic               auto_en;
    logic [AGREE_W-1:0] agree_thr;
    logic [FLAT_W-1:0]  flat_sq;
  } cfg_t;

  // Per-item flags handed from the classify stage to the debounce stage
  typedef struct packed {
    logic             read_ok;
    logic             locked;
    logic [ROT_W-1:0] disp;
    logic [ROT_W-1:0] rot;
    pose_e            pose;
  } cls_t;

endpackage

[rtl/tod_classify.sv]
// Classify stage: squares both axes and picks the dominant-axis rotation.
// Depends on tod_pkg.
module tod_classify #(
  parameter int ACCEL_WIDTH = tod_pkg::ACCEL_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic                            read_ok_i,
  input  logic                            locked_i,
  input  logic [tod_pkg::ROT_W-1:0]       disp_i,
  input  logic signed [ACCEL_WIDTH-1:0]   accel_x_i,
  input  logic signed [ACCEL_WIDTH-1:0]   accel_y_i,
  output logic                            valid_o,
  output tod_pkg::cls_t                   cls_o,
  output logic [2*ACCEL_WIDTH-1:0]        sq_x_o,
  output logic [2*ACCEL_WIDTH-1:0]        sq_y_o
);
  import tod_pkg::*;

  logic                          valid_q;
  cls_t                          cls_d, cls_q;
  logic signed [2*ACCEL_WIDTH-1:0] sq_x_d, sq_y_d;
  logic [2*ACCEL_WIDTH-1:0]      sq_x_q, sq_y_q;
  logic signed [ACCEL_WIDTH:0]   x_ext, y_ext;
  logic [ACCEL_WIDTH:0]          mag_x, mag_y;

  // Magnitudes one bit wider so the most negative reading stays exact
  assign x_ext = {accel_x_i[ACCEL_WIDTH-1], accel_x_i};
  assign y_ext = {accel_y_i[ACCEL_WIDTH-1], accel_y_i};
  assign mag_x = x_ext[ACCEL_WIDTH] ? (ACCEL_WIDTH+1)'(-x_ext) : x_ext;
  assign mag_y = y_ext[ACCEL_WIDTH] ? (ACCEL_WIDTH+1)'(-y_ext) : y_ext;

  // Signed square equals the square of the magnitude
  assign sq_x_d = (2*ACCEL_WIDTH)'(accel_x_i) * (2*ACCEL_WIDTH)'(accel_x_i);
  assign sq_y_d = (2*ACCEL_WIDTH)'(accel_y_i) * (2*ACCEL_WIDTH)'(accel_y_i);

  always_comb begin
    cls_d.read_ok = read_ok_i;
    cls_d.locked  = locked_i;
    cls_d.disp    = disp_i;
    if (mag_x >= mag_y) begin
      cls_d.rot  = accel_x_i[ACCEL_WIDTH-1] ? ROT_180 : ROT_0;
      cls_d.pose = accel_x_i[ACCEL_WIDTH-1] ? POSE_LANDSCAPE : POSE_LANDSCAPE_FLIP;
    end else begin
      cls_d.rot  = accel_y_i[ACCEL_WIDTH-1] ? ROT_270 : ROT_90;
      cls_d.pose = accel_y_i[ACCEL_WIDTH-1] ? POSE_PORTRAIT_RIGHT : POSE_PORTRAIT_LEFT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cls_q  <= cls_d;
      sq_x_q <= sq_x_d;
      sq_y_q <= sq_y_d;
    end
  end

  assign valid_o = valid_q;
  assign cls_o   = cls_q;
  assign sq_x_o  = sq_x_q;
  assign sq_y_o  = sq_y_q;

endmodule

[rtl/tod_debounce.sv]
// Debounce stage: flat test, candidate/agree tracking, commit decision,
// counters and the result register. Depends on tod_pkg.
module tod_debounce #(
  parameter int ACCEL_WIDTH = tod_pkg::ACCEL_WIDTH_DEF,
  parameter int COUNT_WIDTH = tod_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  tod_pkg::cls_t                 cls_i,
  input  logic [2*ACCEL_WIDTH-1:0]      sq_x_i,
  input  logic [2*ACCEL_WIDTH-1:0]      sq_y_i,
  input  tod_pkg::cfg_t                 cfg_i,
  output logic                          valid_o,
  output logic                          commit_valid_o,
  output logic [tod_pkg::ROT_W-1:0]     commit_rotation_o,
  output tod_pkg::pose_e                pose_o,
  output logic [tod_pkg::AGREE_W-1:0]   agree_count_o,
  output logic                          decision_known_o,
  output logic [tod_pkg::ROT_W-1:0]     last_decision_o,
  output logic [COUNT_WIDTH-1:0]        sample_count_o,
  output logic [COUNT_WIDTH-1:0]        error_count_o,
  output logic [COUNT_WIDTH-1:0]        commit_count_o
);
  import tod_pkg::*;

  localparam int SUM_W = 2*ACCEL_WIDTH + 1;
  localparam int CMP_W = (SUM_W > FLAT_W) ? SUM_W : FLAT_W;

  logic                   valid_q;
  logic                   commit_d, commit_q;
  logic [ROT_W-1:0]       crot_d, crot_q;
  pose_e                  pose_d, pose_q;
  logic                   cand_v_d, cand_v_q;
  logic [ROT_W-1:0]       cand_rot_d, cand_rot_q;
  logic [AGREE_W-1:0]     run_d, run_q;
  logic                   dk_d, dk_q;
  logic [ROT_W-1:0]       ld_d, ld_q;
  logic [COUNT_WIDTH-1:0] samp_d, samp_q, err_d, err_q, cm_d, cm_q;
  logic [SUM_W-1:0]       sq_sum;
  logic                   is_flat;

  assign sq_sum  = SUM_W'(sq_x_i) + SUM_W'(sq_y_i);
  assign is_flat = CMP_W'(sq_sum) < CMP_W'(cfg_i.flat_sq);

  always_comb begin
    commit_d   = 1'b0;
    crot_d     = ROT_0;
    pose_d     = POSE_NONE;
    cand_v_d   = cand_v_q;
    cand_rot_d = cand_rot_q;
    run_d      = run_q;
    dk_d       = dk_q;
    ld_d       = ld_q;
    samp_d     = samp_q;
    err_d      = err_q;
    cm_d       = cm_q;
    if (!cls_i.read_ok) begin
      // failed read keeps the candidate and its run
      err_d = err_q + COUNT_WIDTH'(1);
    end else begin
      samp_d = samp_q + COUNT_WIDTH'(1);
      if (cls_i.locked || !cfg_i.auto_en) begin
        cand_v_d = 1'b0;
        run_d    = '0;
      end else if (is_flat) begin
        pose_d   = POSE_FLAT;
        cand_v_d = 1'b0;
        run_d    = '0;
      end else begin
        pose_d = cls_i.pose;
        if (cand_v_q && (cand_rot_q == cls_i.rot)) begin
          run_d = (run_q == RUN_MAX) ? RUN_MAX : run_q + AGREE_W'(1);
        end else begin
          cand_v_d   = 1'b1;
          cand_rot_d = cls_i.rot;
          run_d      = AGREE_W'(1);
        end
        if (run_d >= cfg_i.agree_thr) begin
          dk_d = 1'b1;
          ld_d = cls_i.rot;
          if (cls_i.rot != cls_i.disp) begin
            commit_d = 1'b1;
            crot_d   = cls_i.rot;
            cm_d     = cm_q + COUNT_WIDTH'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      cand_v_q   <= 1'b0;
      cand_rot_q <= ROT_0;
      run_q      <= '0;
      dk_q       <= 1'b0;
      ld_q       <= ROT_0;
      samp_q     <= '0;
      err_q      <= '0;
      cm_q       <= '0;
    end else if (en_i) begin
      valid_q <= valid_i;
      if (valid_i) begin
        cand_v_q   <= cand_v_d;
        cand_rot_q <= cand_rot_d;
        run_q      <= run_d;
        dk_q       <= dk_d;
        ld_q       <= ld_d;
        samp_q     <= samp_d;
        err_q      <= err_d;
        cm_q       <= cm_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      commit_q <= commit_d;
      crot_q   <= crot_d;
      pose_q   <= pose_d;
    end
  end

  // State registers load together with the result, so they read as the result
  assign valid_o           = valid_q;
  assign commit_valid_o    = commit_q;
  assign commit_rotation_o = crot_q;
  assign pose_o            = pose_q;
  assign agree_count_o     = run_q;
  assign decision_known_o  = dk_q;
  assign last_decision_o   = ld_q;
  assign sample_count_o    = samp_q;
  assign error_count_o     = err_q;
  assign commit_count_o    = cm_q;

endmodule

[rtl/tilt_orientation_debouncer_unit.sv]
// Tilt orientation debouncer, top level: stream ports, config registers,
// input register and the classify/debounce stages.
// Depends on tod_pkg, tod_classify and tod_debounce.
//
// Usage:
//  - s_axis carries one accelerometer sample per item; tuser is read_ok
//    (0 = failed read). m_axis returns exactly one result item per input.
//  - cfg port: write-only, always ready; index 0 auto_enable, 1
//    agree_threshold, 2 flat_threshold_sq. Write only while no item is
//    in flight.
//  - Pipeline: an accepted item passes the input, square and result
//    registers in that order before m_axis_tvalid rises. Throughput: one
//    item per cycle while m_axis is not stalled, since the debounce state
//    updates in the same cycle that it consumes the registered squares.
//  - Reset clears the pipeline, candidate, decision and all counters, and
//    loads the register defaults (auto on, threshold 3, 0.35 g squared).
//  - A stalled m_axis holds its result; upstream stages keep filling until
//    all three are full, then s_axis_tready drops.
module tilt_orientation_debouncer_unit #(
  parameter int ACCEL_WIDTH = tod_pkg::ACCEL_WIDTH_DEF,
  parameter int COUNT_WIDTH = tod_pkg::COUNT_WIDTH_DEF,
  localparam int IN_DATA_W  = ((2*ACCEL_WIDTH + 3 + 7) / 8) * 8,
  localparam int OUT_RAW_W  = 13 + 3*COUNT_WIDTH,
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: accel_x, accel_y, locked, display_rotation, zero pad
  input  logic [IN_DATA_W-1:0]             s_axis_tdata,
  // tuser: read_ok
  input  logic                             s_axis_tuser,
  // master stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: commit_valid, commit_rotation, pose, agree_count, decision_known,
  //        last_decision, sample_count, error_count, commit_count, zero pad
  output logic [OUT_DATA_W-1:0]            m_axis_tdata,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tod_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tod_pkg::FLAT_W-1:0]       cfg_data_i
);
  import tod_pkg::*;

  cfg_t cfg_q;

  // input register
  logic                          v0_q;
  logic                          ok_q, lock_q;
  logic [ROT_W-1:0]              disp_q;
  logic signed [ACCEL_WIDTH-1:0] ax_q, ay_q;

  logic en0, en1, en2;
  logic v1, v2;
  cls_t cls;
  logic [2*ACCEL_WIDTH-1:0] sq_x, sq_y;

  logic                   commit_valid, decision_known;
  logic [ROT_W-1:0]       commit_rotation, last_decision;
  pose_e                  pose;
  logic [AGREE_W-1:0]     agree_count;
  logic [COUNT_WIDTH-1:0] sample_count, error_count, commit_count;

  // Each stage moves when the one after it is empty or moving
  assign en2 = !v2 || m_axis_tready;
  assign en1 = !v1 || en2;
  assign en0 = !v0_q || en1;
  assign s_axis_tready = en0;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_en   <= AUTO_EN_RST;
      cfg_q.agree_thr <= AGREE_RST;
      cfg_q.flat_sq   <= FLAT_SQ_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_AUTO_ENABLE: cfg_q.auto_en   <= cfg_data_i[0];
        CFG_AGREE_THR:   cfg_q.agree_thr <= cfg_data_i[AGREE_W-1:0];
        CFG_FLAT_SQ:     cfg_q.flat_sq   <= cfg_data_i;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en0) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && s_axis_tvalid) begin
      ok_q   <= s_axis_tuser;
      ax_q   <= s_axis_tdata[ACCEL_WIDTH-1:0];
      ay_q   <= s_axis_tdata[2*ACCEL_WIDTH-1:ACCEL_WIDTH];
      lock_q <= s_axis_tdata[2*ACCEL_WIDTH];
      disp_q <= s_axis_tdata[2*ACCEL_WIDTH+2:2*ACCEL_WIDTH+1];
    end
  end

  tod_classify #(
    .ACCEL_WIDTH(ACCEL_WIDTH)
  ) u_classify (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en1),
    .valid_i   (v0_q),
    .read_ok_i (ok_q),
    .locked_i  (lock_q),
    .disp_i    (disp_q),
    .accel_x_i (ax_q),
    .accel_y_i (ay_q),
    .valid_o   (v1),
    .cls_o     (cls),
    .sq_x_o    (sq_x),
    .sq_y_o    (sq_y)
  );

  tod_debounce #(
    .ACCEL_WIDTH(ACCEL_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_debounce (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en2),
    .valid_i           (v1),
    .cls_i             (cls),
    .sq_x_i            (sq_x),
    .sq_y_i            (sq_y),
    .cfg_i             (cfg_q),
    .valid_o           (v2),
    .commit_valid_o    (commit_valid),
    .commit_rotation_o (commit_rotation),
    .pose_o            (pose),
    .agree_count_o     (agree_count),
    .decision_known_o  (decision_known),
    .last_decision_o   (last_decision),
    .sample_count_o    (sample_count),
    .error_count_o     (error_count),
    .commit_count_o    (commit_count)
  );

  assign m_axis_tvalid = v2;
  assign m_axis_tdata  = OUT_DATA_W'({commit_count, error_count, sample_count,
                                      last_decision, decision_known, agree_count,
                                      pose, commit_rotation, commit_valid});

  // A commit always records its rotation as the latest decision
  a_commit_decided: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2 && commit_valid) |-> (decision_known && (last_decision == commit_rotation)))
    else $error("commit without matching decision");

  // Flat or unclassified samples never commit
  a_no_commit_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2 && ((pose == POSE_NONE) || (pose == POSE_FLAT))) |-> !commit_valid)
    else $error("commit on flat or unclassified sample");

  // Every processed item bumps exactly one of the sample and error counters
  a_one_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en2 && v1) |=> (COUNT_WIDTH'(sample_count + error_count) ==
                     COUNT_WIDTH'($past(sample_count + error_count) + 1'b1)))
    else $error("sample/error count did not advance by one");

endmodule

[dv/testbench.sv]
// Self-checking bench for tilt_orientation_debouncer_unit: directed and random samples,
// per-item prediction of the classify/debounce result, bursty sender, stalling receiver.
// Depends on tod_pkg and the RTL of the block.
module testbench;
  import tod_pkg::*;

  localparam int IN_DATA_W    = 40;   // 2*16 + 3 bits, padded to bytes
  localparam int OUT_DATA_W   = 112;  // 13 + 3*32 bits, padded to bytes
  localparam int PIPE_LATENCY = 3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;  // unmapped, writes ignored

  typedef struct packed {
    logic                 read_ok;
    logic signed [15:0]   accel_x;
    logic signed [15:0]   accel_y;
    logic                 locked;
    logic [ROT_W-1:0]     disp_rot;
  } tilt_sample_t;

  typedef struct packed {
    logic               commit;
    logic [ROT_W-1:0]   commit_rot;
    pose_e              pose;
    logic [AGREE_W-1:0] agree;
    logic               known;
    logic [ROT_W-1:0]   last_rot;
    logic [31:0]        samples;
    logic [31:0]        errors;
    logic [31:0]        commits;
  } orient_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [FLAT_W-1:0]      cfg_data_i = '0;

  always #4 clk_i = ~clk_i;

  tilt_orientation_debouncer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Mirror of the block's registers and debounce state
  logic               auto_en     = AUTO_EN_RST;
  logic [AGREE_W-1:0] agree_thr   = AGREE_RST;
  logic [FLAT_W-1:0]  flat_sq     = FLAT_SQ_RST;
  logic               cand_valid  = 1'b0;
  logic [ROT_W-1:0]   cand_rot    = ROT_0;
  logic [AGREE_W-1:0] agree_run   = '0;
  logic               decided     = 1'b0;
  logic [ROT_W-1:0]   decided_rot = ROT_0;
  logic [31:0]        n_samples   = '0;
  logic [31:0]        n_errors    = '0;
  logic [31:0]        n_commits   = '0;

  orient_result_t pending_orient_q[$];
  int unsigned    fail_count  = 0;
  int unsigned    cycle_count = 0;

  // Sender burst/gap control, receiver stall control
  int  burst_left   = 0;
  bit  tx_gaps_on   = 1'b1;
  int  rx_hold_left = 0;
  int  rx_mode      = 0;
  int  rx_mode_left = 0;

  // Random run state: a candidate rotation repeated with random content
  logic [ROT_W-1:0] run_rot  = ROT_0;
  logic [ROT_W-1:0] run_disp = ROT_0;
  int               run_left = 0;

  // Classify one sample and advance the debounce state; returns the result it causes.
  function automatic orient_result_t predict_orientation(input tilt_sample_t smp);
    orient_result_t   res;
    logic [16:0]      mag_x;
    logic [16:0]      mag_y;
    logic [33:0]      sum_sq;
    logic [ROT_W-1:0] rot;
    res = '0;
    res.pose = POSE_NONE;
    if (!smp.read_ok) begin
      n_errors++;
    end else begin
      n_samples++;
      if (smp.locked || !auto_en) begin
        cand_valid = 1'b0;
        agree_run = '0;
      end else begin
        mag_x = smp.accel_x[15] ? 17'(~{1'b1, smp.accel_x} + 17'd1) : {1'b0, smp.accel_x};
        mag_y = smp.accel_y[15] ? 17'(~{1'b1, smp.accel_y} + 17'd1) : {1'b0, smp.accel_y};
        sum_sq = 34'(mag_x) * 34'(mag_x) + 34'(mag_y) * 34'(mag_y);
        if (sum_sq < 34'(flat_sq)) begin
          res.pose = POSE_FLAT;
          cand_valid = 1'b0;
          agree_run = '0;
        end else begin
          // x wins ties
          if (mag_x >= mag_y) begin
            rot = smp.accel_x[15] ? ROT_180 : ROT_0;
            res.pose = smp.accel_x[15] ? POSE_LANDSCAPE : POSE_LANDSCAPE_FLIP;
          end else begin
            rot = smp.accel_y[15] ? ROT_270 : ROT_90;
            res.pose = smp.accel_y[15] ? POSE_PORTRAIT_RIGHT : POSE_PORTRAIT_LEFT;
          end
          if (cand_valid && cand_rot == rot) begin
            if (agree_run != RUN_MAX) agree_run++;
          end else begin
            cand_valid = 1'b1;
            cand_rot = rot;
            agree_run = 4'd1;
          end
          if (agree_run >= agree_thr) begin
            decided = 1'b1;
            decided_rot = rot;
            if (rot != smp.disp_rot) begin
              res.commit = 1'b1;
              res.commit_rot = rot;
              n_commits++;
            end
          end
        end
      end
    end
    res.agree    = agree_run;
    res.known    = decided;
    res.last_rot = decided_rot;
    res.samples  = n_samples;
    res.errors   = n_errors;
    res.commits  = n_commits;
    return res;
  endfunction

  function automatic tilt_sample_t mk_sample(input bit ok, input int x, input int y,
                                             input bit lk, input logic [ROT_W-1:0] disp);
    tilt_sample_t smp;
    smp.read_ok  = ok;
    smp.accel_x  = 16'(x);
    smp.accel_y  = 16'(y);
    smp.locked   = lk;
    smp.disp_rot = disp;
    return smp;
  endfunction

  // Clean reading whose dominant axis and sign give rotation rot
  function automatic tilt_sample_t tilted_sample(input logic [ROT_W-1:0] rot,
                                                 input logic [ROT_W-1:0] disp);
    int dom;
    int minor;
    dom = $urandom_range(1500, 32768);
    minor = $urandom_range(0, dom - 1);
    if ($urandom_range(0, 1)) minor = -minor;
    case (rot)
      ROT_0:   return mk_sample(1'b1, (dom > 32767) ? 32767 : dom, minor, 1'b0, disp);
      ROT_180: return mk_sample(1'b1, -dom, minor, 1'b0, disp);
      ROT_90:  return mk_sample(1'b1, minor, (dom > 32767) ? 32767 : dom, 1'b0, disp);
      default: return mk_sample(1'b1, minor, -dom, 1'b0, disp);
    endcase
  endfunction

  // Mostly agreeing runs; the rest failed reads, locked, flat and raw noise
  function automatic tilt_sample_t next_run_sample();
    tilt_sample_t smp;
    int unsigned  pick;
    if (run_left == 0) begin
      run_rot  = 2'($urandom_range(0, 3));
      run_left = $urandom_range(1, 18);
      run_disp = $urandom_range(0, 1) ? run_rot : 2'($urandom_range(0, 3));
    end
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      smp = tilted_sample(run_rot, run_disp);
      run_left--;
    end else begin
      smp = mk_sample(1'b1, $urandom, $urandom, 1'b0, 2'($urandom_range(0, 3)));
      if (pick < 80) begin
        smp.read_ok = 1'b0;
      end else if (pick < 86) begin
        smp.locked = 1'b1;
      end else if (pick < 92) begin
        smp.accel_x = 16'(int'($urandom_range(0, 2400)) - 1200);
        smp.accel_y = 16'(int'($urandom_range(0, 2400)) - 1200);
      end else begin
        smp.read_ok = 1'($urandom_range(0, 1));
        smp.locked  = 1'($urandom_range(0, 1));
      end
    end
    return smp;
  endfunction

  // One item on s_axis; valid stays up across back-to-back items of a burst.
  task automatic send_sample(input tilt_sample_t smp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, smp.disp_rot, smp.locked, smp.accel_y, smp.accel_x};
    s_axis_tuser  <= smp.read_ok;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_orient_q.push_back(predict_orientation(smp));
  endtask

  // Stop offering and let every pending result come back.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_orient_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // Caller makes sure the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FLAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_AUTO_ENABLE: auto_en   = data[0];
      CFG_AGREE_THR:   agree_thr = data[AGREE_W-1:0];
      CFG_FLAT_SQ:     flat_sq   = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reset defaults: failed reads, flat edge, each rotation, ties, locked.
  task automatic test_directed_cases();
    send_sample(mk_sample(1'b0, -32768, 32767, 1'b1, ROT_270));  // failed read
    send_sample(mk_sample(1'b1, 0, 0, 1'b0, ROT_0));              // dead flat
    send_sample(mk_sample(1'b1, 1433, 0, 1'b0, ROT_0));           // just under flat limit
    send_sample(mk_sample(1'b1, 1434, 0, 1'b0, ROT_0));           // just over
    send_sample(mk_sample(1'b1, -32768, 0, 1'b0, ROT_0));
    send_sample(mk_sample(1'b1, -32768, 5, 1'b0, ROT_0));
    send_sample(mk_sample(1'b0, 32767, 32767, 1'b0, ROT_0));      // failed read keeps run
    send_sample(mk_sample(1'b1, -20000, -19999, 1'b0, ROT_0));    // agreed, commit 180
    repeat (3) send_sample(mk_sample(1'b1, 32767, -32768, 1'b0, ROT_270));  // agreed, no commit
    send_sample(mk_sample(1'b1, 32767, 0, 1'b1, ROT_0));          // lock clears candidate
    send_sample(mk_sample(1'b1, 32767, 32767, 1'b0, ROT_90));     // tie goes to x
    send_sample(mk_sample(1'b1, -32767, 32767, 1'b0, ROT_90));
    repeat (3) send_sample(mk_sample(1'b1, 100, 32767, 1'b0, ROT_0));
    send_sample(mk_sample(1'b1, 0, -1434, 1'b0, ROT_0));
  endtask

  // Register extremes: saturating run, threshold zero, auto off, flat limits, masking.
  task automatic test_config_extremes();
    wait_idle();
    write_reg(CFG_AGREE_THR, 31'd15);
    repeat (18) send_sample(mk_sample(1'b1, 30000, -200, 1'b0, ROT_90));
    wait_idle();
    write_reg(CFG_AGREE_THR, 31'd0);
    send_sample(mk_sample(1'b1, -300, 9000, 1'b0, ROT_90));
    send_sample(mk_sample(1'b1, -300, 9000, 1'b0, ROT_0));
    wait_idle();
    write_reg(CFG_AUTO_ENABLE, 31'd0);
    write_reg(CFG_AGREE_THR, 31'd1);
    repeat (3) send_sample(mk_sample(1'b1, -9000, 10, 1'b0, ROT_0));
    wait_idle();
    write_reg(CFG_AUTO_ENABLE, 31'd1);
    write_reg(CFG_FLAT_SQ, 31'd0);
    send_sample(mk_sample(1'b1, 0, 0, 1'b0, ROT_90));             // nothing is below zero
    wait_idle();
    write_reg(CFG_FLAT_SQ, 31'd1000000);
    send_sample(mk_sample(1'b1, 1000, 0, 1'b0, ROT_90));          // equal is not flat
    send_sample(mk_sample(1'b1, 999, 44, 1'b0, ROT_90));
    send_sample(mk_sample(1'b1, 0, -1000, 1'b0, ROT_90));
    wait_idle();
    write_reg(CFG_FLAT_SQ, 31'h7FFF_FFFF);
    send_sample(mk_sample(1'b1, -32768, -32768, 1'b0, ROT_0));
    send_sample(mk_sample(1'b1, 32767, 32767, 1'b0, ROT_0));
    wait_idle();
    // upper data bits must be dropped; spare index must change nothing
    write_reg(CFG_IDX_SPARE, 31'($urandom));
    write_reg(CFG_AUTO_ENABLE, 31'h5555_5555);
    write_reg(CFG_AGREE_THR, 31'h2AAA_AAA5);
    write_reg(CFG_FLAT_SQ, FLAT_SQ_RST);
    repeat (6) send_sample(mk_sample(1'b1, -4000, -12000, 1'b0, ROT_0));
  endtask

  task automatic test_random_runs();
    int n_items;
    for (int ph = 0; ph < 10; ph++) begin
      wait_idle();
      n_items = 170;
      write_reg(CFG_AUTO_ENABLE, 31'd1);
      write_reg(CFG_FLAT_SQ, FLAT_SQ_RST);
      case (ph)
        0: write_reg(CFG_AGREE_THR, 31'(AGREE_RST));
        1: write_reg(CFG_AGREE_THR, 31'd1);
        2: write_reg(CFG_AGREE_THR, 31'd15);
        3: begin
          write_reg(CFG_AGREE_THR, 31'($urandom_range(1, 15)));
          write_reg(CFG_FLAT_SQ, 31'($urandom_range(0, 60000000)));
        end
        4: begin
          write_reg(CFG_AGREE_THR, 31'd2);
          write_reg(CFG_FLAT_SQ, 31'd0);
        end
        5: begin
          write_reg(CFG_AGREE_THR, 31'($urandom_range(1, 15)));
          write_reg(CFG_FLAT_SQ, 31'($urandom_range(0, 400000000)));
        end
        6: write_reg(CFG_AGREE_THR, 31'd0);
        7: begin
          write_reg(CFG_AGREE_THR, 31'd5);
          write_reg(CFG_FLAT_SQ, 31'($urandom_range(0, 32'h7FFF_FFFF)));
        end
        8: begin
          write_reg(CFG_AUTO_ENABLE, 31'd0);
          n_items = 40;
        end
        default: write_reg(CFG_AGREE_THR, 31'd4);
      endcase
      repeat (n_items) send_sample(next_run_sample());
    end
  endtask

  // Long receiver hold while the sender keeps offering back to back.
  task automatic test_backpressure();
    wait_idle();
    write_reg(CFG_AGREE_THR, 31'd2);
    rx_hold_left = 400;
    tx_gaps_on = 1'b0;
    repeat (40) send_sample(next_run_sample());
    tx_gaps_on = 1'b1;
    wait_idle();
  endtask

  // Receiver: changes stall pattern now and then; a requested hold overrides it.
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left--;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(20, 200);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    orient_result_t got;
    orient_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.commit     = m_axis_tdata[0];
      got.commit_rot = m_axis_tdata[2:1];
      got.pose       = pose_e'(m_axis_tdata[5:3]);
      got.agree      = m_axis_tdata[9:6];
      got.known      = m_axis_tdata[10];
      got.last_rot   = m_axis_tdata[12:11];
      got.samples    = m_axis_tdata[44:13];
      got.errors     = m_axis_tdata[76:45];
      got.commits    = m_axis_tdata[108:77];
      if (pending_orient_q.size() == 0) begin
        if (fail_count < 10) $display("unexpected result item: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_orient_q.pop_front();
        if (got !== want) begin
          if (fail_count < 10) begin
            $display({"exp commit=%0d rot=%0d pose=%0d agree=%0d known=%0d last=%0d",
                      " s=%0d e=%0d c=%0d"},
                     want.commit, want.commit_rot, want.pose, want.agree, want.known,
                     want.last_rot, want.samples, want.errors, want.commits);
            $display({"got commit=%0d rot=%0d pose=%0d agree=%0d known=%0d last=%0d",
                      " s=%0d e=%0d c=%0d"},
                     got.commit, got.commit_rot, got.pose, got.agree, got.known,
                     got.last_rot, got.samples, got.errors, got.commits);
          end
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_config_extremes();
    test_random_runs();
    test_backpressure();
    wait_idle();
    repeat (20) @(posedge clk_i);
    fail_count += pending_orient_q.size();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tod_pkg.sv
rtl/tod_classify.sv
rtl/tod_debounce.sv
rtl/tilt_orientation_debouncer_unit.sv
dv/testbench.sv
